// ===== src/ulf_pkg.sv =====
// Shared constants, types and the notice suffix scanner for the UART line framer.
`default_nettype none

package ulf_pkg;

    // Line buffer geometry
    localparam int MAX_LINE   = 64;
    localparam int LEN_W      = $clog2(MAX_LINE + 1);
    localparam int ADDR_W     = $clog2(MAX_LINE);
    localparam int NOTICE_LEN = 7;

    // Control bytes
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    // Characters of the two link notices
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_N    = 8'h4E;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_T    = 8'h54;

    // Result kinds
    localparam logic KIND_LINE   = 1'b0;
    localparam logic KIND_NOTICE = 1'b1;

    // Longest buffer tail that is a prefix of either notice
    typedef enum logic [3:0] {
        M_NONE,
        M_O,
        M_OK,
        M_OKP,
        M_C,
        M_CO,
        M_CON,
        M_L,
        M_LO,
        M_LOS
    } match_t;

    // One stored entry: match state after the byte, then the byte
    localparam int ENTRY_W = 8 + $bits(match_t);

    typedef struct packed {
        match_t nxt;
        logic   hit_up;
        logic   hit_down;
    } scan_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESTORE,
        ST_NOTICE,
        ST_DRAIN
    } fsm_t;

    // Advance the suffix matcher by one appended byte
    function automatic scan_t scan_step(match_t cur, logic [7:0] c);
        scan_t r;
        r.hit_up   = 1'b0;
        r.hit_down = 1'b0;
        r.nxt      = (c == CH_O) ? M_O : M_NONE;
        case (cur)
            M_NONE: ;
            M_O:
            begin
                if (c == CH_K)
                    r.nxt = M_OK;
            end
            M_OK:
            begin
                if (c == CH_PLUS)
                    r.nxt = M_OKP;
            end
            M_OKP:
            begin
                if (c == CH_C)
                    r.nxt = M_C;
                else if (c == CH_L)
                    r.nxt = M_L;
            end
            M_C:
            begin
                if (c == CH_O)
                    r.nxt = M_CO;
            end
            M_CO:
            begin
                if (c == CH_N)
                    r.nxt = M_CON;
                else if (c == CH_K)
                    r.nxt = M_OK;
            end
            M_CON:
            begin
                if (c == CH_N)
                    r.hit_up = 1'b1;
            end
            M_L:
            begin
                if (c == CH_O)
                    r.nxt = M_LO;
            end
            M_LO:
            begin
                if (c == CH_S)
                    r.nxt = M_LOS;
                else if (c == CH_K)
                    r.nxt = M_OK;
            end
            M_LOS:
            begin
                if (c == CH_T)
                    r.hit_down = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/ulf_channels.sv =====
// Valid/ready channel interfaces for received bytes and framer results.
`default_nettype none

interface ulf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ulf_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] line_byte;
    logic       last;
    logic       link_up;

    modport source (output valid, output kind, output line_byte, output last,
                    output link_up, input ready);
    modport sink (input valid, input kind, input line_byte, input last,
                  input link_up, output ready);
endinterface

`default_nettype wire

// ===== src/uart_line_framer_with_link_notices.sv =====
// Top level of the UART line framer with link notices.
`default_nettype none

// Gathers received bytes into a 64-entry line buffer held in one RAM.
// Carriage returns are dropped. A line feed on a non-empty buffer sends
// the line out as a run of words (kind 0), the final one flagged last; a
// line feed on an empty buffer does nothing. Any other byte is appended;
// a byte that arrives on a full buffer throws the line away.
// Each RAM entry keeps the byte and the notice-matcher state after it, so
// when a line ends in "OK+CONN" or "OK+LOST" the seven characters are
// removed, the link flag is set or cleared and a single notice word
// (kind 1, last 1) is sent; recovering the matcher state takes one RAM
// read, so such a byte holds off new bytes for the restore state, longer
// if the output is stalled. A line drains at one word per cycle unless
// the output stalls, through the RAM read port, new bytes being held off
// until the last word is taken into the output register. The RAM needs
// no clearing after reset; only entries below the current length matter.
module uart_line_framer_with_link_notices (
    input  wire logic clk,
    input  wire logic rst_n,
    ulf_rx_if.sink    rx,
    ulf_res_if.source res
);
    import ulf_pkg::*;

    fsm_t               state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    match_t             tail_reg, tail_next;
    logic               connected_reg, connected_next;
    logic [LEN_W-1:0]   drain_len_reg, drain_len_next;
    logic [LEN_W-1:0]   addr_reg, addr_next;
    logic               pend_reg, pend_next;
    logic               pend_last_reg, pend_last_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg, out_kind_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;
    logic               out_link_reg, out_link_next;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    scan_t              scan;
    logic               out_free;
    logic               move;
    logic               issue;
    logic [LEN_W-1:0]   rest_len;
    logic [7:0]         rd_byte;
    match_t             rd_match;

    // Line buffer memory
    ulf_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_byte  = rd_data[7:0];
    assign rd_match = match_t'(rd_data[ENTRY_W-1:8]);
    assign scan     = scan_step(tail_reg, rx.rx_byte);
    assign out_free = !out_valid_reg || res.ready;
    assign rest_len = len_reg - LEN_W'(NOTICE_LEN);
    assign move     = (state_reg == ST_DRAIN) && pend_reg && out_free;
    assign issue    = (state_reg == ST_DRAIN) && (addr_reg < drain_len_reg)
                      && (!pend_reg || move);

    assign rx.ready = (state_reg == ST_IDLE);

    // Next state, buffer control and output register loads
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        tail_next      = tail_reg;
        connected_next = connected_reg;
        drain_len_next = drain_len_reg;
        addr_next      = addr_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;

        out_valid_next = out_valid_reg && !res.ready;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_link_next  = out_link_reg;

        wr_en   = 1'b0;
        wr_addr = len_reg[ADDR_W-1:0];
        wr_data = {scan.nxt, rx.rx_byte};
        rd_en   = 1'b0;
        rd_addr = addr_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (rx.valid)
                begin
                    if (rx.rx_byte == BYTE_CR)
                    begin
                        // drop carriage return
                    end
                    else if (rx.rx_byte == BYTE_LF)
                    begin
                        // start draining a non-empty line
                        if (len_reg != '0)
                        begin
                            drain_len_next = len_reg;
                            addr_next      = '0;
                            pend_next      = 1'b0;
                            len_next       = '0;
                            tail_next      = M_NONE;
                            state_next     = ST_DRAIN;
                        end
                    end
                    else if (len_reg == LEN_W'(MAX_LINE))
                    begin
                        // discard an overlong line
                        len_next  = '0;
                        tail_next = M_NONE;
                    end
                    else if (scan.hit_up || scan.hit_down)
                    begin
                        // strip the notice and fetch the matcher state below it
                        connected_next = scan.hit_up;
                        len_next       = len_reg - LEN_W'(NOTICE_LEN - 1);
                        rd_en          = 1'b1;
                        rd_addr        = rest_len[ADDR_W-1:0];
                        state_next     = ST_RESTORE;
                    end
                    else
                    begin
                        // append the byte
                        wr_en     = 1'b1;
                        len_next  = len_reg + LEN_W'(1);
                        tail_next = scan.nxt;
                    end
                end
            end
            ST_RESTORE:
            begin
                tail_next = (len_reg == '0) ? M_NONE : rd_match;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_NOTICE;
                    out_byte_next  = '0;
                    out_last_next  = 1'b1;
                    out_link_next  = connected_reg;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_NOTICE;
                end
            end
            ST_NOTICE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_NOTICE;
                    out_byte_next  = '0;
                    out_last_next  = 1'b1;
                    out_link_next  = connected_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                // hand the fetched byte to the output register
                if (move)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_LINE;
                    out_byte_next  = rd_byte;
                    out_last_next  = pend_last_reg;
                    out_link_next  = connected_reg;
                    pend_next      = 1'b0;
                    if (pend_last_reg)
                        state_next = ST_IDLE;
                end
                // fetch the next byte
                if (issue)
                begin
                    rd_en          = 1'b1;
                    addr_next      = addr_reg + LEN_W'(1);
                    pend_next      = 1'b1;
                    pend_last_next = ((addr_reg + LEN_W'(1)) == drain_len_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            tail_reg      <= M_NONE;
            connected_reg <= 1'b0;
            drain_len_reg <= '0;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            tail_reg      <= tail_next;
            connected_reg <= connected_next;
            drain_len_reg <= drain_len_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload registers
    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_link_reg <= out_link_next;
    end

    assign res.valid     = out_valid_reg;
    assign res.kind      = out_kind_reg;
    assign res.line_byte = out_byte_reg;
    assign res.last      = out_last_reg;
    assign res.link_up   = out_link_reg;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_LINE))
        else $error("line length beyond buffer size");

    a_write_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_IDLE) && !rd_en)
        else $error("buffer write outside an append");

    a_drain_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (addr_reg <= drain_len_reg) && (drain_len_reg != '0))
        else $error("drain address past line end");

    a_notice_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == KIND_NOTICE)) |->
            (out_byte_reg == 8'd0) && out_last_reg)
        else $error("malformed notice word");

    a_restore_follows_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESTORE) |-> $past(state_reg) == ST_IDLE)
        else $error("restore without a notice match");
`endif

endmodule

`default_nettype wire

// ===== src/ulf_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module ulf_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 12
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== bench/uart_line_framer_with_link_notices_test.sv =====
// Self-checking bench for the UART line framer: byte stimulus, line/notice prediction, word checks.
`default_nettype none

module uart_line_framer_with_link_notices_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ulf_pkg::*;

    localparam logic [8*NOTICE_LEN-1:0] TEXT_UP   = "OK+CONN";
    localparam logic [8*NOTICE_LEN-1:0] TEXT_DOWN = "OK+LOST";
    localparam int GAP_MAX        = 13;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 100;
    localparam int CALM_TAIL      = 30;
    localparam int RANDOM_ITEMS   = 20;

    typedef struct packed {
        logic       kind;
        logic [7:0] line_byte;
        logic       last;
        logic       link_up;
    } framer_word_t;

    logic clk = 1'b0;
    logic rst_n;

    ulf_rx_if  rx_ch ();
    ulf_res_if res_ch ();

    uart_line_framer_with_link_notices dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    // Bytes waiting to be sent and words the framer still owes
    logic [7:0]   pending_bytes[$];
    framer_word_t due_words[$];

    // Predicted framer state
    logic [7:0] line_copy[MAX_LINE];
    int         line_fill = 0;
    logic       link_flag = 1'b0;

    int   mismatches  = 0;
    int   bytes_taken = 0;
    bit   byte_taken  = 1'b0;
    int   send_gap    = 0;
    int   take_gap    = 0;
    logic holding     = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // True when the buffered line ends in the given seven characters
    function automatic bit tail_matches(input logic [8*NOTICE_LEN-1:0] text);
        int base;
        int i;
        if (line_fill < NOTICE_LEN)
            return 1'b0;
        base = line_fill - NOTICE_LEN;
        for (i = 0; i < NOTICE_LEN; i++)
        begin
            if (line_copy[base + i] != text[8*(NOTICE_LEN-1-i) +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the predicted framer by one received byte, queue the words it owes
    function automatic void frame_byte(input logic [7:0] c);
        framer_word_t w;
        bit up_hit;
        bit down_hit;
        int i;
        if (c == BYTE_CR)
            return;
        if (c == BYTE_LF)
        begin
            for (i = 0; i < line_fill; i++)
            begin
                w.kind      = KIND_LINE;
                w.line_byte = line_copy[i];
                w.last      = (i == line_fill - 1);
                w.link_up   = link_flag;
                due_words.push_back(w);
            end
            line_fill = 0;
            return;
        end
        // append, or throw the line away when full
        if (line_fill < MAX_LINE)
        begin
            line_copy[line_fill] = c;
            line_fill++;
        end
        else
            line_fill = 0;
        up_hit   = tail_matches(TEXT_UP);
        down_hit = tail_matches(TEXT_DOWN);
        if (!up_hit && !down_hit)
            return;
        link_flag = up_hit;
        line_fill -= NOTICE_LEN;
        w.kind      = KIND_NOTICE;
        w.line_byte = 8'h00;
        w.last      = 1'b1;
        w.link_up   = link_flag;
        due_words.push_back(w);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
    endfunction

    function automatic void add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            pending_bytes.push_back(s[i]);
    endfunction

    // Random line content: anything but the two control bytes
    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == BYTE_CR || b == BYTE_LF);
        return b;
    endfunction

    // Whole notices, prefixes of them and overlapping near-misses
    function automatic string pick_fragment();
        case ($urandom_range(0, 7))
            0: return "OK+CONN";
            1: return "OK+LOST";
            2: return "OK";
            3: return "OK+";
            4: return "OK+CO";
            5: return "OK+LOS";
            6: return "OKOK+LOST";
            default: return "O";
        endcase
    endfunction

    // Offer the next byte; hold it until taken
    always @(negedge clk)
    begin
        if (!rst_n)
            rx_ch.valid <= 1'b0;
        else if (rx_ch.valid && !byte_taken)
            ;
        else if (send_gap > 0)
        begin
            send_gap    <= send_gap - 1;
            rx_ch.valid <= 1'b0;
        end
        else if (pending_bytes.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
        begin
            send_gap    <= $urandom_range(0, GAP_MAX - 1);
            rx_ch.valid <= 1'b0;
        end
        else if (pending_bytes.size() > 0)
        begin
            rx_ch.valid   <= 1'b1;
            rx_ch.rx_byte <= pending_bytes[0];
        end
        else
            rx_ch.valid <= 1'b0;
        byte_taken = 1'b0;
    end

    // Predict on every accepted byte
    always @(posedge clk)
    begin
        if (rst_n && rx_ch.valid && rx_ch.ready)
        begin
            frame_byte(rx_ch.rx_byte);
            void'(pending_bytes.pop_front());
            bytes_taken++;
            byte_taken = 1'b1;
        end
    end

    // Stall the result side in bursts, or for the long hold-off
    always @(negedge clk)
    begin
        if (!rst_n || holding)
            res_ch.ready <= 1'b0;
        else if (take_gap > 0)
        begin
            take_gap     <= take_gap - 1;
            res_ch.ready <= 1'b0;
        end
        else if (pending_bytes.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
        begin
            take_gap     <= $urandom_range(0, GAP_MAX - 1);
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    // Block the result side long enough for the framer to back up its input
    initial
    begin : long_holdoff
        wait (bytes_taken >= 40);
        @(negedge clk) holding <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        @(negedge clk) holding <= 1'b0;
    end

    // Compare each accepted word with the oldest one owed
    always @(posedge clk)
    begin : check_words
        framer_word_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (due_words.size() == 0)
                report_mismatch("word with none expected", int'(res_ch.line_byte), 0);
            else
            begin
                want = due_words.pop_front();
                if (res_ch.kind !== want.kind)
                    report_mismatch("kind", int'(res_ch.kind), int'(want.kind));
                if (res_ch.line_byte !== want.line_byte)
                    report_mismatch("line_byte", int'(res_ch.line_byte),
                                    int'(want.line_byte));
                if (res_ch.last !== want.last)
                    report_mismatch("last", int'(res_ch.last), int'(want.last));
                if (res_ch.link_up !== want.link_up)
                    report_mismatch("link_up", int'(res_ch.link_up), int'(want.link_up));
            end
        end
    end

    initial
    begin : run
        int stop_at;
        int n;
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        res_ch.ready  = 1'b0;

        // Directed: empty line, dropped CR, byte extremes, overlapping notice
        add_byte(BYTE_LF);
        add_byte(BYTE_CR);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h55);
        add_byte(BYTE_CR);
        add_byte(8'hAA);
        add_text("OK+COK+CONN");
        add_byte(BYTE_LF);
        add_text("OK+LOST");
        add_byte(BYTE_LF);

        // Exactly full line, then one that overflows and restarts
        repeat (MAX_LINE) add_byte(data_byte());
        add_byte(BYTE_LF);
        repeat (MAX_LINE + 2) add_byte(data_byte());
        add_byte(BYTE_LF);

        // Random: mostly well-formed lines, some noise and broken lines
        stop_at = pending_bytes.size() + RANDOM_ITEMS;
        while (pending_bytes.size() < stop_at)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    n = $urandom_range(0, 12);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 4) == 0)
                            add_text(pick_fragment());
                        else if ($urandom_range(0, 11) == 0)
                            add_byte(BYTE_CR);
                        else
                            add_byte(data_byte());
                    end
                    if ($urandom_range(0, 1) == 1)
                        add_byte(BYTE_CR);
                    add_byte(BYTE_LF);
                end
                5:
                begin
                    add_text($urandom_range(0, 1) ? "OK+CONN" : "OK+LOST");
                    add_byte(BYTE_CR);
                    add_byte(BYTE_LF);
                end
                6:
                    repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
                7:
                    add_text($urandom_range(0, 1) ? "OKOK+CONN+LOST" : "OKOK+LOST+CONN");
                8:
                begin
                    repeat ($urandom_range(1, 6)) add_byte(data_byte());
                    add_text(pick_fragment());
                end
                default:
                begin
                    // in a quarter of cases, a notice that lands exactly on a full buffer; then a line feed
                    if ($urandom_range(0, 3) == 0)
                    begin
                        repeat (MAX_LINE - NOTICE_LEN) add_byte(data_byte());
                        add_text("OK+CONN");
                    end
                    add_byte(BYTE_LF);
                end
            endcase
        end
        add_byte(BYTE_LF);

        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        while (pending_bytes.size() > 0)
            @(posedge clk);
        while (due_words.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (due_words.size() != 0)
            report_mismatch("words never produced", due_words.size(), 0);

        if (mismatches == 0)
            $display("uart_line_framer_with_link_notices_test: clean");
        else
            $display("uart_line_framer_with_link_notices_test: errors");
        $finish;
    end

    initial
    begin : watchdog
        #(2_000_000);
        $display("uart_line_framer_with_link_notices_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
